FILE: rtl/core/fir_pkg.sv
// Shared types, widths and codes for the fixed-point FIR filter.
package fir_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 32;
    localparam int COEF_INDEX_W = 6;
    localparam int NUM_TAPS_W   = 7;

    // Default tap storage and register reset value
    localparam int DEF_MAX_TAP_COUNT = 64;
    localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RESET = 7'd64;

    // Transaction mode codes
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_OUT
    } state_t;

    // Control from the sequencer to the multiply-accumulate datapath
    typedef struct packed {
        logic acc_clear;
        logic mul_valid;
        logic out_load;
        logic out_last;
    } fir_mac_ctrl_t;

endpackage

FILE: rtl/core/fir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fir_mac.sv
// Multiply-accumulate datapath: product, 1.31 truncation, accumulator, output register.
module fir_mac #(
    parameter int MAX_TAP_COUNT = fir_pkg::DEF_MAX_TAP_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fir_pkg::fir_mac_ctrl_t              ctrl,
    input  logic signed [fir_pkg::COEF_W-1:0]   tap_coef,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] tap_sample,
    output logic                                out_free,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                block_last
);

    localparam int PROD_W = fir_pkg::COEF_W + fir_pkg::SAMPLE_W;
    localparam int SH_W   = PROD_W - 15;
    localparam int ACC_W  = fir_pkg::COEF_W + $clog2(MAX_TAP_COUNT);
    localparam int HI_W   = ACC_W - 31;

    logic signed [PROD_W-1:0]            prod_reg;
    logic                                prod_valid_reg;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [SH_W-1:0]              prod_sh;
    logic signed [fir_pkg::COEF_W-1:0]   term;
    logic [HI_W-1:0]                     acc_hi;
    logic signed [fir_pkg::SAMPLE_W-1:0] y_sat;
    logic                                out_valid_reg;
    logic signed [fir_pkg::SAMPLE_W-1:0] sample_out_reg;
    logic                                block_last_reg;

    // Register the coefficient times sample product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mul_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_valid)
        begin
            prod_reg <= tap_coef * tap_sample;
        end
    end

    // Truncate to 1.31 (floor); only minus one squared overflows, clip it
    always_comb
    begin
        prod_sh = SH_W'(prod_reg >>> 15);
        if (!prod_sh[SH_W-1] && prod_sh[fir_pkg::COEF_W-1])
        begin
            term = {1'b0, {(fir_pkg::COEF_W-1){1'b1}}};
        end
        else
        begin
            term = prod_sh[fir_pkg::COEF_W-1:0];
        end
    end

    // Accumulate in 7.31 (default MAX_TAP_COUNT)
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-fir_pkg::COEF_W){term[fir_pkg::COEF_W-1]}}, term};
        end
    end

    // Truncate to 1.15 and saturate
    always_comb
    begin
        acc_hi = acc_reg[ACC_W-1:31];
        if ((&acc_hi) || !(|acc_hi))
        begin
            y_sat = acc_reg[31:16];
        end
        else if (acc_hi[HI_W-1])
        begin
            y_sat = {1'b1, {(fir_pkg::SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(fir_pkg::SAMPLE_W-1){1'b1}}};
        end
    end

    // Hold the result until the output transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            sample_out_reg <= y_sat;
            block_last_reg <= ctrl.out_last;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign block_last = block_last_reg;

endmodule

FILE: rtl/core/fir_ctrl.sv
// Sequencer: clearing pass, coefficient writes, tap walk with in-memory history shift.
module fir_ctrl #(
    parameter int MAX_TAP_COUNT = fir_pkg::DEF_MAX_TAP_COUNT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [fir_pkg::NUM_TAPS_W-1:0]          cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    mode,
    input  logic signed [fir_pkg::SAMPLE_W-1:0]     sample_in,
    input  logic [fir_pkg::COEF_INDEX_W-1:0]        coef_index,
    input  logic signed [fir_pkg::COEF_W-1:0]       coef_value,
    input  logic                                    block_end,
    output logic                                    hist_we,
    output logic [$clog2(MAX_TAP_COUNT)-1:0]        hist_waddr,
    output logic [fir_pkg::SAMPLE_W-1:0]            hist_wdata,
    output logic [$clog2(MAX_TAP_COUNT)-1:0]        hist_raddr,
    input  logic [fir_pkg::SAMPLE_W-1:0]            hist_rdata,
    output logic                                    coef_we,
    output logic [$clog2(MAX_TAP_COUNT)-1:0]        coef_waddr,
    output logic [fir_pkg::COEF_W-1:0]              coef_wdata,
    output logic [$clog2(MAX_TAP_COUNT)-1:0]        coef_raddr,
    output logic signed [fir_pkg::SAMPLE_W-1:0]     tap_sample,
    output fir_pkg::fir_mac_ctrl_t                  mac_ctrl,
    input  logic                                    out_free
);

    localparam int AW    = $clog2(MAX_TAP_COUNT);
    localparam int CNT_W = $clog2(MAX_TAP_COUNT + 1);
    localparam int CMP_W = (CNT_W > fir_pkg::NUM_TAPS_W) ? CNT_W : fir_pkg::NUM_TAPS_W;

    fir_pkg::state_t                     state_reg, state_next;
    logic [fir_pkg::NUM_TAPS_W-1:0]      num_taps_reg;
    logic [AW-1:0]                       k_reg;
    logic [AW-1:0]                       clr_cnt_reg;
    logic signed [fir_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                last_reg;
    logic                                s1_valid_reg;
    logic                                s1_zero_reg;
    logic [AW-1:0]                       s1_addr_reg;

    logic [CMP_W-1:0] taps_wide;
    logic [CMP_W-1:0] eff_wide;
    logic [CNT_W-1:0] eff_taps;
    logic             clearing;
    logic             issue;
    logic             sample_accept;
    logic             coef_accept;
    logic             clear_done;
    logic             k_zero;

    // Clamp the tap count to 1..MAX_TAP_COUNT
    always_comb
    begin
        taps_wide = CMP_W'(num_taps_reg);
        if (taps_wide == '0)
        begin
            eff_wide = CMP_W'(1);
        end
        else if (taps_wide > CMP_W'(MAX_TAP_COUNT))
        begin
            eff_wide = CMP_W'(MAX_TAP_COUNT);
        end
        else
        begin
            eff_wide = taps_wide;
        end
        eff_taps = eff_wide[CNT_W-1:0];
    end

    assign clear_done = (clr_cnt_reg == AW'(MAX_TAP_COUNT - 1));
    assign k_zero     = (k_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fir_pkg::ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            fir_pkg::ST_IDLE:
            begin
                if (in_valid && (mode == fir_pkg::MODE_FILTER))
                begin
                    state_next = fir_pkg::ST_RUN;
                end
            end
            fir_pkg::ST_RUN:
            begin
                if (k_zero)
                begin
                    state_next = fir_pkg::ST_DRAIN1;
                end
            end
            fir_pkg::ST_DRAIN1:
            begin
                state_next = fir_pkg::ST_DRAIN2;
            end
            fir_pkg::ST_DRAIN2:
            begin
                state_next = fir_pkg::ST_OUT;
            end
            fir_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir_pkg::ST_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        clearing = 1'b0;
        issue    = 1'b0;
        mac_ctrl = '0;
        case (state_reg)
            fir_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            fir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            fir_pkg::ST_RUN:
            begin
                issue = 1'b1;
            end
            fir_pkg::ST_OUT:
            begin
                mac_ctrl.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        sample_accept      = in_valid && in_ready && (mode == fir_pkg::MODE_FILTER);
        coef_accept        = in_valid && in_ready && (mode == fir_pkg::MODE_COEF)
                             && (CMP_W'(coef_index) < eff_wide);
        mac_ctrl.acc_clear = sample_accept;
        mac_ctrl.mul_valid = s1_valid_reg;
        mac_ctrl.out_last  = last_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fir_pkg::ST_CLEAR;
            num_taps_reg <= fir_pkg::NUM_TAPS_RESET;
            clr_cnt_reg  <= '0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            if (cfg_we)
            begin
                num_taps_reg <= cfg_wdata;
            end
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (sample_accept)
            begin
                k_reg <= AW'(eff_taps - CNT_W'(1));
            end
            else if (issue && !k_zero)
            begin
                k_reg <= k_reg - AW'(1);
            end
        end
    end

    // Capture the sample and track the tap in flight
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            sample_reg <= sample_in;
            last_reg   <= block_end;
        end
        s1_zero_reg <= k_zero;
        s1_addr_reg <= k_reg;
    end

    // Walk taps from oldest to newest: read entry k-1, write it back at k
    assign hist_raddr = k_reg - AW'(1);
    assign coef_raddr = k_reg;
    assign tap_sample = s1_zero_reg ? sample_reg : $signed(hist_rdata);

    assign hist_we    = clearing || s1_valid_reg;
    assign hist_waddr = clearing ? clr_cnt_reg : s1_addr_reg;
    assign hist_wdata = clearing ? '0 : tap_sample;

    // Coefficient store: zero during clearing, else the accepted write
    assign coef_we    = clearing || coef_accept;
    assign coef_waddr = clearing ? clr_cnt_reg : AW'(coef_index);
    assign coef_wdata = clearing ? '0 : coef_value;

endmodule

FILE: rtl/core/fir_filter_fixed_point.sv
// Top level of the programmable-length direct-form fixed-point FIR filter.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    mode, sample_in, coef_index, coef_value, block_end
//  out      out_valid / out_ready  sample_out, block_last
//  cfg      cfg_we (no wait)       cfg_wdata = num_taps
//
// A sample transaction runs through the N active taps, N being the active tap count:
// one tap per cycle through the single read port of each memory and the shared
// multiplier, then the drain states ST_DRAIN1 and ST_DRAIN2 and the output state ST_OUT.
// A coefficient transaction is accepted in ST_IDLE, and the sequencer stays there.
// After reset a clearing pass zeroes both memories, with in_ready low. A stalled output
// holds the result while transactions are still accepted; the next result waits in ST_OUT.
module fir_filter_fixed_point #(
    parameter int MAX_TAP_COUNT = fir_pkg::DEF_MAX_TAP_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fir_pkg::NUM_TAPS_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [fir_pkg::COEF_INDEX_W-1:0]    coef_index,
    input  logic signed [fir_pkg::COEF_W-1:0]   coef_value,
    input  logic                                block_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                block_last
);

    localparam int AW = $clog2(MAX_TAP_COUNT);

    logic                                hist_we;
    logic [AW-1:0]                       hist_waddr;
    logic [fir_pkg::SAMPLE_W-1:0]        hist_wdata;
    logic [AW-1:0]                       hist_raddr;
    logic [fir_pkg::SAMPLE_W-1:0]        hist_rdata;
    logic                                coef_we;
    logic [AW-1:0]                       coef_waddr;
    logic [fir_pkg::COEF_W-1:0]          coef_wdata;
    logic [AW-1:0]                       coef_raddr;
    logic [fir_pkg::COEF_W-1:0]          coef_rdata;
    logic signed [fir_pkg::SAMPLE_W-1:0] tap_sample;
    fir_pkg::fir_mac_ctrl_t              mac_ctrl;
    logic                                out_free;

    // Sequencer
    fir_ctrl #(
        .MAX_TAP_COUNT(MAX_TAP_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .block_end  (block_end),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .hist_raddr (hist_raddr),
        .hist_rdata (hist_rdata),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_wdata (coef_wdata),
        .coef_raddr (coef_raddr),
        .tap_sample (tap_sample),
        .mac_ctrl   (mac_ctrl),
        .out_free   (out_free)
    );

    // Sample history (delay line)
    fir_ram #(
        .WIDTH(fir_pkg::SAMPLE_W),
        .DEPTH(MAX_TAP_COUNT)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Tap weights
    fir_ram #(
        .WIDTH(fir_pkg::COEF_W),
        .DEPTH(MAX_TAP_COUNT)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // Multiply-accumulate and output register
    fir_mac #(
        .MAX_TAP_COUNT(MAX_TAP_COUNT)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .tap_coef   ($signed(coef_rdata)),
        .tap_sample (tap_sample),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .block_last (block_last)
    );

endmodule

FILE: test/fir_checker.sv
// Scoreboard for the FIR filter: mirrors taps, weights and history, predicts and compares.
module fir_checker #(
    parameter int MAX_TAP_COUNT = fir_pkg::DEF_MAX_TAP_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fir_pkg::NUM_TAPS_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                mode,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [fir_pkg::COEF_INDEX_W-1:0]    coef_index,
    input  logic signed [fir_pkg::COEF_W-1:0]   coef_value,
    input  logic                                block_end,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                block_last,
    output int                                  fail_count,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PRODUCT_MAX = 64'sh0000_0000_7FFF_FFFF;

    typedef struct {
        logic signed [fir_pkg::SAMPLE_W-1:0] value;
        logic                                last;
    } filtered_t;

    logic [fir_pkg::NUM_TAPS_W-1:0]      taps_reg;
    logic signed [fir_pkg::SAMPLE_W-1:0] history [MAX_TAP_COUNT];
    logic signed [fir_pkg::COEF_W-1:0]   weights [MAX_TAP_COUNT];
    filtered_t                           expected_outputs [$];

    initial fail_count = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Clamp the programmed tap count to the usable range
    function automatic int active_taps();
        if (taps_reg == '0)
            return 1;
        if (int'(taps_reg) > MAX_TAP_COUNT)
            return MAX_TAP_COUNT;
        return int'(taps_reg);
    endfunction

    // Shift a sample into the delay line and return the saturated 1.15 output
    function automatic logic signed [fir_pkg::SAMPLE_W-1:0] filter_sample(
        input logic signed [fir_pkg::SAMPLE_W-1:0] smp
    );
        int     n;
        int     k;
        longint acc;
        longint prod;
        longint y;
        n = active_taps();
        for (k = n - 1; k > 0; k--)
            history[k] = history[k-1];
        history[0] = smp;
        acc = 0;
        for (k = 0; k < n; k++)
        begin
            // Floor the 2.46 product to 1.31; only -1 * -1 overflows
            prod = (longint'(weights[k]) * longint'(history[k])) >>> 15;
            if (prod > PRODUCT_MAX)
                prod = PRODUCT_MAX;
            acc += prod;
        end
        y = acc >>> 16;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return y[fir_pkg::SAMPLE_W-1:0];
    endfunction

    // Track every transaction in acceptance order
    always @(posedge clk or negedge rst_n)
    begin
        filtered_t exp_item;
        if (!rst_n)
        begin
            taps_reg = fir_pkg::NUM_TAPS_RESET;
            for (int i = 0; i < MAX_TAP_COUNT; i++)
            begin
                history[i] = '0;
                weights[i] = '0;
            end
            expected_outputs.delete();
            outstanding <= 0;
        end
        else
        begin
            // Compare the output transaction with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                    report_mismatch($sformatf("unexpected result sample_out=%0d",
                                              sample_out));
                else
                begin
                    exp_item = expected_outputs.pop_front();
                    if (sample_out !== exp_item.value)
                        report_mismatch($sformatf("sample_out got %0d want %0d",
                                                  sample_out, exp_item.value));
                    if (block_last !== exp_item.last)
                        report_mismatch($sformatf("block_last got %0b want %0b",
                                                  block_last, exp_item.last));
                end
            end

            // Apply the input transaction to the mirrored state
            if (in_valid && in_ready)
            begin
                if (mode == fir_pkg::MODE_COEF)
                begin
                    if (int'(coef_index) < active_taps())
                        weights[coef_index] = coef_value;
                end
                else
                begin
                    exp_item.value = filter_sample(sample_in);
                    exp_item.last  = block_end;
                    expected_outputs.push_back(exp_item);
                end
            end

            if (cfg_we)
                taps_reg = cfg_wdata;

            outstanding <= expected_outputs.size();
        end
    end

endmodule

FILE: test/tb_fir_filter_fixed_point.sv
// Testbench top for the FIR filter: clock, reset, stimulus, flow control and verdict.
module tb_fir_filter_fixed_point;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PHASES          = 12;
    localparam int     ITEMS_PER_PHASE = 160;
    localparam int     DRAIN_CYCLES    = 8;
    localparam int     SETTLE_CYCLES   = 80;
    localparam int     HOLD_CYCLES     = 400;
    localparam longint CYCLE_LIMIT     = 1_000_000;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                cfg_we     = 1'b0;
    logic [fir_pkg::NUM_TAPS_W-1:0]      cfg_wdata  = '0;
    logic                                in_valid   = 1'b0;
    logic                                in_ready;
    logic                                mode       = fir_pkg::MODE_FILTER;
    logic signed [fir_pkg::SAMPLE_W-1:0] sample_in  = '0;
    logic [fir_pkg::COEF_INDEX_W-1:0]    coef_index = '0;
    logic signed [fir_pkg::COEF_W-1:0]   coef_value = '0;
    logic                                block_end  = 1'b0;
    logic                                out_valid;
    logic                                out_ready  = 1'b0;
    logic signed [fir_pkg::SAMPLE_W-1:0] sample_out;
    logic                                block_last;

    int     fail_count;
    int     outstanding;
    int     send_idle_pct = 16;
    int     recv_idle_pct = 63;
    bit     hold_req      = 1'b0;
    bit     hold_done     = 1'b0;
    int     hold_left     = 0;
    longint cycle_count   = 0;

    always #5 clk = ~clk;

    fir_filter_fixed_point dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .block_end  (block_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .block_last (block_last)
    );

    fir_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .sample_in   (sample_in),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .block_end   (block_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .block_last  (block_last),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Drive output flow control; hold off for a long stretch once when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run if it hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Present one transaction and hold it until accepted
    task automatic drive_item(input logic m, input logic signed [fir_pkg::SAMPLE_W-1:0] smp,
                              input logic [fir_pkg::COEF_INDEX_W-1:0] idx,
                              input logic signed [fir_pkg::COEF_W-1:0] weight,
                              input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        sample_in  <= smp;
        coef_index <= idx;
        coef_value <= weight;
        block_end  <= last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Wait until the filter is idle, then program the tap count
    task automatic write_taps(input int value);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[fir_pkg::NUM_TAPS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [fir_pkg::COEF_W-1:0] pick_weight();
        logic signed [fir_pkg::COEF_W-1:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: w = 32'sh8000_0000;
                    1: w = 32'sh7FFF_FFFF;
                    2: w = '0;
                    default: w = '1;
                endcase
            end
            1, 2, 3, 4: ;
            // Small weights keep the sum out of saturation
            default: w = w >>> $urandom_range(4, 12);
        endcase
        return w;
    endfunction

    function automatic logic signed [fir_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(24))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return fir_pkg::SAMPLE_W'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        int tap_plan [PHASES];
        int teff;
        int done;
        int idx;

        tap_plan = '{1, 64, 0, 127, 2, 5, 64, 16, 33, 3, 63, 12};

        // Reset, then wait for the clearing pass to finish
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);

        // Directed: weight extremes, ignored writes, -1 * -1, saturation both ways
        write_taps(8);
        drive_item(fir_pkg::MODE_COEF, 16'sh7FFF, 6'd0, 32'sh8000_0000, 1'b1);
        drive_item(fir_pkg::MODE_COEF, 16'sh0000, 6'd63, 32'sh7FFF_FFFF, 1'b0);
        drive_item(fir_pkg::MODE_COEF, 16'sh0000, 6'd8, 32'sh1234_5678, 1'b1);
        drive_item(fir_pkg::MODE_FILTER, 16'sh8000, 6'd0, '0, 1'b0);
        drive_item(fir_pkg::MODE_FILTER, 16'sh7FFF, 6'd63, '1, 1'b1);
        drive_item(fir_pkg::MODE_FILTER, 16'sh0000, 6'd0, '0, 1'b0);
        for (int i = 1; i < 8; i++)
            drive_item(fir_pkg::MODE_COEF, 16'sh0000, fir_pkg::COEF_INDEX_W'(i),
                       32'sh7FFF_FFFF, 1'b0);
        for (int i = 0; i < 8; i++)
            drive_item(fir_pkg::MODE_FILTER, 16'sh7FFF, 6'd0, '0, i[0]);
        for (int i = 0; i < 3; i++)
            drive_item(fir_pkg::MODE_FILTER, 16'sh8000, 6'd0, '0, 1'b1);

        // Random phases over a spread of tap counts
        for (int p = 0; p < PHASES; p++)
        begin
            case (p / 4)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_taps(tap_plan[p]);
            teff = (tap_plan[p] == 0) ? 1 : (tap_plan[p] > 64 ? 64 : tap_plan[p]);
            if (p == 9)
                hold_req = 1'b1;
            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(99) < 18)
                begin
                    // Mostly in-range weight updates, some past the tap count
                    if ($urandom_range(99) < 85)
                        idx = $urandom_range(teff - 1);
                    else
                        idx = $urandom_range(63);
                    drive_item(fir_pkg::MODE_COEF, pick_sample(),
                               fir_pkg::COEF_INDEX_W'(idx),
                               pick_weight(), 1'($urandom_range(1)));
                    if (idx < teff)
                        done++;
                end
                else
                begin
                    drive_item(fir_pkg::MODE_FILTER, pick_sample(),
                               fir_pkg::COEF_INDEX_W'($urandom_range(63)),
                               fir_pkg::COEF_W'($urandom), 1'($urandom_range(1)));
                    done++;
                end
            end
        end

        // Drain and give the verdict
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/fir_pkg.sv
rtl/core/fir_ram.sv
rtl/core/fir_mac.sv
rtl/core/fir_ctrl.sv
rtl/core/fir_filter_fixed_point.sv
test/fir_checker.sv
test/tb_fir_filter_fixed_point.sv
